>>> rtl/core/pkcs7_unpad_checker_defines.svh
// assertion macros shared by the pkcs7 unpad checker rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef PKCS7_UNPAD_CHECKER_DEFINES_SVH
`define PKCS7_UNPAD_CHECKER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PKCS7U_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("pkcs7 unpad checker: same-cycle check failed");

// next-cycle implication, checked out of reset
`define PKCS7U_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pkcs7 unpad checker: next-cycle check failed");

`endif

>>> rtl/core/pkcs7u_pkg.sv
// shared types and constants for the pkcs7 unpad checker
// no dependencies
`default_nettype none

package pkcs7u_pkg;

  localparam int unsigned BlockBytesDef = 16;
  localparam int unsigned LengthBitsDef = 16;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned StatusW       = 3;
  localparam int unsigned KeptW         = 16;

  typedef enum logic [StatusW-1:0] {
    StOk             = 3'd0,
    StBadLength      = 3'd1,
    StBadPadValue    = 3'd2,
    StBadPadContent  = 3'd3,
    StTooLong        = 3'd4
  } status_e;

  // one result beat
  typedef struct packed {
    logic [ByteW-1:0]   out_byte;
    logic               byte_valid;
    logic               end_of_message;
    logic [StatusW-1:0] status;
    logic [KeptW-1:0]   kept_length;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/pkcs7u_obuf.sv
// output register for result beats, valid/ready toward the receiver
// depends on pkcs7u_pkg
`default_nettype none

module pkcs7u_obuf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire pkcs7u_pkg::result_t push_data_i,
  output logic                     free_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output pkcs7u_pkg::result_t      out_data_o
);

  logic                valid_q;
  pkcs7u_pkg::result_t data_q;

  // slot is free when empty or the held beat leaves this cycle
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i && free_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && free_o) begin
      data_q <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pkcs7_unpad_checker.sv
// pkcs7 padding removal over a byte stream cut into blocks of BLOCK_BYTES
// depends on pkcs7u_pkg, pkcs7u_obuf and pkcs7_unpad_checker_defines.svh
//
// input channel: one message byte per beat (in_byte_i, is_last_i), valid/ready.
// output channel: data beats (byte_valid_o = 1) and one closing status beat
// per message (end_of_message_o = 1, status_o, kept_length_o), valid/ready.
// the newest BLOCK_BYTES bytes are held back; each older byte leaves as a
// data beat when the byte that pushes it out is taken.
// an ordinary byte is accepted and then written into the tail line before
// ready returns. the last byte then runs a sequencer with one shared byte
// comparator: evaluate, pad compare (one pad byte each), drain of the
// BLOCK_BYTES - pad held data bytes and status; a failed check goes to status.
// results leave through an output register; a stalled receiver holds the
// sequencer only in cycles that must emit a beat.
// reset clears the byte count, overflow flag, tail occupancy and output valid;
// the tail line itself needs no clearing.
`default_nettype none
`include "pkcs7_unpad_checker_defines.svh"

module pkcs7_unpad_checker #(
  parameter int unsigned BLOCK_BYTES = pkcs7u_pkg::BlockBytesDef,
  parameter int unsigned LENGTH_BITS = pkcs7u_pkg::LengthBitsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [pkcs7u_pkg::ByteW-1:0]       in_byte_i,
  input  wire logic                               is_last_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [pkcs7u_pkg::ByteW-1:0]            out_byte_o,
  output logic                                    byte_valid_o,
  output logic                                    end_of_message_o,
  output logic [pkcs7u_pkg::StatusW-1:0]          status_o,
  output logic [pkcs7u_pkg::KeptW-1:0]            kept_length_o
);

  localparam int unsigned IdxW  = $clog2(BLOCK_BYTES);
  localparam int unsigned HeldW = $clog2(BLOCK_BYTES + 1);
  localparam logic [LENGTH_BITS-1:0]       CountMax = '1;
  localparam logic [pkcs7u_pkg::ByteW-1:0] BlockB8  = pkcs7u_pkg::ByteW'(BLOCK_BYTES);
  localparam logic [IdxW-1:0]              IdxLast  = IdxW'(BLOCK_BYTES - 1);
  localparam logic [HeldW-1:0]             HeldFull = HeldW'(BLOCK_BYTES);

  typedef enum logic [2:0] {
    SIdle,
    SShift,
    SEval,
    SCheck,
    SDrain,
    SStat
  } state_e;

  state_e                         state_q;
  logic [pkcs7u_pkg::ByteW-1:0]   byte_q;
  logic                           last_q;
  logic [pkcs7u_pkg::ByteW-1:0]   tail_q [BLOCK_BYTES];
  logic [HeldW-1:0]               held_q;
  logic [LENGTH_BITS-1:0]         count_q;
  logic                           ovf_q;
  logic [IdxW-1:0]                pos_q;
  logic [IdxW-1:0]                idx_q;
  pkcs7u_pkg::status_e            stat_q;

  logic                           full;
  logic                           slot_free;
  logic                           step_ok;
  logic                           push;
  pkcs7u_pkg::result_t            push_data;
  pkcs7u_pkg::result_t            out_data;
  logic [pkcs7u_pkg::ByteW-1:0]   tail_rd;
  logic [pkcs7u_pkg::ByteW-1:0]   drain_end;
  logic [LENGTH_BITS-1:0]         kept_full;
  logic [31:0]                    kept_ext;

  assign full      = (held_q == HeldFull);
  assign step_ok   = !full || slot_free;
  assign tail_rd   = tail_q[idx_q];
  assign drain_end = BlockB8 - byte_q;
  assign kept_full = count_q - LENGTH_BITS'(byte_q);
  assign kept_ext  = 32'(kept_full);

  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    push      = 1'b0;
    push_data = '0;
    unique case (state_q)
      SShift: begin
        push               = full;
        push_data.out_byte = tail_q[0];
        push_data.byte_valid = 1'b1;
      end
      SDrain: begin
        push                 = 1'b1;
        push_data.out_byte   = tail_rd;
        push_data.byte_valid = 1'b1;
      end
      SStat: begin
        push                     = 1'b1;
        push_data.end_of_message = 1'b1;
        push_data.status         = stat_q;
        push_data.kept_length    = (stat_q == pkcs7u_pkg::StOk) ?
                                   kept_ext[pkcs7u_pkg::KeptW-1:0] : '0;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // tail delay line: fill in place, then shift once full
  always_ff @(posedge clk_i) begin
    if (state_q == SShift && step_ok) begin
      if (full) begin
        for (int i = 0; i < BLOCK_BYTES - 1; i++) begin
          tail_q[i] <= tail_q[i + 1];
        end
        tail_q[BLOCK_BYTES - 1] <= byte_q;
      end else begin
        tail_q[held_q[IdxW-1:0]] <= byte_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      byte_q  <= '0;
      last_q  <= 1'b0;
      held_q  <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      pos_q   <= '0;
      idx_q   <= '0;
      stat_q  <= pkcs7u_pkg::StOk;
    end else begin
      unique case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            byte_q  <= in_byte_i;
            last_q  <= is_last_i;
            state_q <= SShift;
          end
        end
        SShift: begin
          if (step_ok) begin
            if (!full) begin
              held_q <= held_q + HeldW'(1);
            end
            if (count_q == CountMax) begin
              ovf_q <= 1'b1;
            end else begin
              count_q <= count_q + LENGTH_BITS'(1);
              pos_q   <= (pos_q == IdxLast) ? '0 : pos_q + IdxW'(1);
            end
            state_q <= last_q ? SEval : SIdle;
          end
        end
        SEval: begin
          priority if (ovf_q) begin
            stat_q  <= pkcs7u_pkg::StTooLong;
            state_q <= SStat;
          end else if (count_q == '0 || pos_q != '0) begin
            stat_q  <= pkcs7u_pkg::StBadLength;
            state_q <= SStat;
          end else if (byte_q == '0 || byte_q > BlockB8) begin
            stat_q  <= pkcs7u_pkg::StBadPadValue;
            state_q <= SStat;
          end else begin
            stat_q  <= pkcs7u_pkg::StOk;
            idx_q   <= IdxW'(drain_end);
            state_q <= SCheck;
          end
        end
        SCheck: begin
          // one pad byte per cycle through the shared comparator
          priority if (tail_rd != byte_q) begin
            stat_q  <= pkcs7u_pkg::StBadPadContent;
            state_q <= SStat;
          end else if (idx_q == IdxLast) begin
            idx_q   <= '0;
            state_q <= (byte_q == BlockB8) ? SStat : SDrain;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        SDrain: begin
          if (slot_free) begin
            idx_q <= idx_q + IdxW'(1);
            if (pkcs7u_pkg::ByteW'(idx_q) + pkcs7u_pkg::ByteW'(1) == drain_end) begin
              state_q <= SStat;
            end
          end
        end
        SStat: begin
          if (slot_free) begin
            held_q  <= '0;
            count_q <= '0;
            ovf_q   <= 1'b0;
            pos_q   <= '0;
            state_q <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  pkcs7u_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .free_o      (slot_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign out_byte_o       = out_data.out_byte;
  assign byte_valid_o     = out_data.byte_valid;
  assign end_of_message_o = out_data.end_of_message;
  assign status_o         = out_data.status;
  assign kept_length_o    = out_data.kept_length;

  // tail occupancy never passes the block size
  `PKCS7U_ASSERT_NOW(a_held_bound, 1'b1, held_q <= HeldFull)
  // one byte at a time: ready drops right after a beat is taken
  `PKCS7U_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o)
  // pad compare only runs on a whole number of blocks with a legal pad value
  `PKCS7U_ASSERT_NOW(a_check_legal, state_q == SCheck,
                     pos_q == '0 && !ovf_q && byte_q != '0 && byte_q <= BlockB8)
  // every result beat is either data or a closing status, never both
  `PKCS7U_ASSERT_NOW(a_beat_kind, out_valid_o, byte_valid_o != end_of_message_o)

endmodule

`default_nettype wire
